>>> rtl/core/hrb_pkg.sv
// Shared action codes, status codes and the result stage type of the history ring buffer.
package hrb_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    localparam int unsigned ROW_OUT_W = 5;
    localparam int unsigned WORD_W    = 16;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] newest_row;
        logic [ROW_OUT_W-1:0] oldest_row;
        logic [ROW_OUT_W-1:0] row_count;
        status_t              status;
        logic                 use_mem;
    } result_t;

endpackage

>>> rtl/core/history_ring_buffer_unit.sv
// History ring buffer: row pointers, blank flags, word memory and the result stages.
// Accepted beats pass the result stage, then the output register. Throughput: one beat
// per cycle unless the master side stalls; the word memory takes one write and one read
// per cycle. Reset clears the pointers, the column counter and the stage valid flags and
// marks every row blank; the word memory is not cleared, so there is no start-up pass.
module history_ring_buffer_unit
    import hrb_pkg::*;
#(
    parameter int unsigned ROWS = 32,
    parameter int unsigned COLS = 80
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // word_value [15:0], read_row [20:16], read_column [27:21], zero [31:28]
    input  logic [31:0] s_axis_tdata,
    // action [1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_word [15:0], newest_row [20:16], oldest_row [25:21], row_count [30:26], zero [31]
    output logic [31:0] m_axis_tdata,
    // status [1:0]
    output logic [1:0]  m_axis_tuser
);

    localparam int unsigned ROW_W  = $clog2(ROWS);
    localparam int unsigned COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int unsigned DEPTH  = ROWS * COLS;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLS - 1);
    localparam logic [ROW_W:0]    ROWS_EXT = (ROW_W + 1)'(ROWS);
    localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLS);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [ROW_W-1:0]  wr_row_reg, wr_row_next;
    logic [ROW_W-1:0]  first_row_reg, first_row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROWS-1:0]   blank_reg, blank_next;

    logic              s1_valid_reg;
    result_t           s1_reg, s1_next;
    logic [WORD_W-1:0] rdata_reg;
    logic              out_valid_reg;
    logic [31:0]       out_data_reg;
    logic [1:0]        out_user_reg;

    action_t           action;
    logic [WORD_W-1:0] word_value;
    logic [4:0]        read_row;
    logic [6:0]        read_column;
    logic              accept;
    logic              out_load;
    logic              wr_en;
    logic              rd_en;
    logic              rd_range_err;
    logic [ROW_W-1:0]  rd_row_idx;
    logic [COL_W-1:0]  rd_col_idx;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ROW_W-1:0]  wr_row_inc;
    logic [ROW_W-1:0]  newest;
    logic [ROW_W:0]    count_ext;
    logic [WORD_W-1:0] read_word;

    function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
        row_inc = (r == LAST_ROW) ? '0 : r + 1'b1;
    endfunction

    function automatic logic [ROW_W-1:0] row_dec(input logic [ROW_W-1:0] r);
        row_dec = (r == '0) ? LAST_ROW : r - 1'b1;
    endfunction

    assign action      = action_t'(s_axis_tuser);
    assign word_value  = s_axis_tdata[15:0];
    assign read_row    = s_axis_tdata[20:16];
    assign read_column = s_axis_tdata[27:21];

    assign out_load      = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || out_load;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign rd_row_idx   = ROW_W'(read_row);
    assign rd_col_idx   = COL_W'(read_column);
    assign rd_range_err = (int'(read_column) >= int'(COLS)) || (int'(read_row) >= int'(ROWS));
    assign wr_addr      = ADDR_W'(wr_row_reg) * COLS_A + ADDR_W'(col_reg);
    assign rd_addr      = ADDR_W'(rd_row_idx) * COLS_A + ADDR_W'(rd_col_idx);
    assign wr_en        = accept && (action == ACT_APPEND);
    assign rd_en        = accept && (action == ACT_READ) && !rd_range_err;
    assign wr_row_inc   = row_inc(wr_row_reg);

    always_comb
    begin
        wr_row_next    = wr_row_reg;
        first_row_next = first_row_reg;
        col_next       = col_reg;
        blank_next     = blank_reg;
        s1_next.status = STATUS_OK;
        s1_next.use_mem = 1'b0;
        if (accept)
        begin
            unique case (action)
                ACT_CLEAR:
                begin
                    wr_row_next    = '0;
                    first_row_next = '0;
                    col_next       = '0;
                    blank_next     = '1;
                end
                ACT_APPEND:
                begin
                    if (col_reg == '0)
                    begin
                        blank_next[wr_row_reg] = 1'b0;
                    end
                    if (col_reg == LAST_COL)
                    begin
                        col_next    = '0;
                        wr_row_next = wr_row_inc;
                        if (wr_row_inc == first_row_reg)
                        begin
                            first_row_next = row_inc(first_row_reg);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                ACT_REMOVE:
                begin
                    col_next = '0;
                    if (first_row_reg != wr_row_reg)
                    begin
                        wr_row_next = row_dec(wr_row_reg);
                    end
                    else
                    begin
                        s1_next.status = STATUS_EMPTY;
                    end
                end
                ACT_READ:
                begin
                    if (rd_range_err)
                    begin
                        s1_next.status = STATUS_RANGE;
                    end
                    else
                    begin
                        s1_next.use_mem = !((rd_col_idx == '0) && blank_reg[rd_row_idx]);
                    end
                end
                default:
                begin
                end
            endcase
        end
        newest    = row_dec(wr_row_next);
        count_ext = {1'b0, wr_row_next} - {1'b0, first_row_next};
        if (wr_row_next < first_row_next)
        begin
            count_ext = count_ext + ROWS_EXT;
        end
        s1_next.newest_row = ROW_OUT_W'(newest);
        s1_next.oldest_row = ROW_OUT_W'(first_row_next);
        s1_next.row_count  = ROW_OUT_W'(count_ext);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= word_value;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_row_reg    <= '0;
            first_row_reg <= '0;
            col_reg       <= '0;
            blank_reg     <= '1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_row_reg    <= wr_row_next;
            first_row_reg <= first_row_next;
            col_reg       <= col_next;
            blank_reg     <= blank_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign read_word = s1_reg.use_mem ? rdata_reg : '0;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (out_load)
        begin
            out_data_reg <= {1'b0, s1_reg.row_count, s1_reg.oldest_row, s1_reg.newest_row,
                             read_word};
            out_user_reg <= s1_reg.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // The column counter never runs past the last word of a row.
    assert property (@(posedge clk) disable iff (!rst_n) col_reg <= LAST_COL)
        else $error("column counter out of range");

    // A held result is never dropped while the master side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("result stage overwritten while stalled");

    // At least one row slot always stays empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (int'(s1_reg.row_count) <= int'(ROWS - 1)))
        else $error("row count exceeds capacity");

    // The write and oldest pointers stay inside the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_row_reg <= LAST_ROW) && (first_row_reg <= LAST_ROW))
        else $error("row pointer out of range");

endmodule

>>> tb/sv/history_ring_checker.sv
// Scoreboard for the history ring buffer: predicts every result beat and compares it.
module history_ring_checker
    import hrb_pkg::*;
#(
    parameter int unsigned ROWS = 32,
    parameter int unsigned COLS = 80
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // word_value [15:0], read_row [20:16], read_column [27:21], zero [31:28]
    input  logic [31:0] s_axis_tdata,
    // action [1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_word [15:0], newest_row [20:16], oldest_row [25:21], row_count [30:26], zero [31]
    input  logic [31:0] m_axis_tdata,
    // status [1:0]
    input  logic [1:0]  m_axis_tuser,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [WORD_W-1:0]    read_word;
        logic [ROW_OUT_W-1:0] newest_row;
        logic [ROW_OUT_W-1:0] oldest_row;
        logic [ROW_OUT_W-1:0] row_count;
        status_t              status;
    } line_result_t;

    logic [WORD_W-1:0] word_mem [ROWS*COLS];
    logic [ROWS-1:0]   blank_rows;
    int unsigned       wr_row;
    int unsigned       old_row;
    int unsigned       col_pos;
    int unsigned       beat_index;
    line_result_t      expected_results [$];

    function automatic int unsigned step_row(input int unsigned r);
        return (r + 1 >= ROWS) ? 0 : r + 1;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("checker: result beat %0d %s got 0x%0h expected 0x%0h",
                 beat_index, field, got, want);
        fail_count = fail_count + 1;
    endtask

    task automatic predict_line_result(input action_t act, input logic [15:0] value,
                                       input logic [4:0] rrow, input logic [6:0] rcol,
                                       output line_result_t res);
        int unsigned newest;
        int unsigned held;
        res = '0;
        res.status = STATUS_OK;
        case (act)
            ACT_CLEAR:
            begin
                blank_rows = '1;
                wr_row = 0;
                old_row = 0;
                col_pos = 0;
            end
            ACT_APPEND:
            begin
                word_mem[wr_row*COLS + col_pos] = value;
                if (col_pos == 0)
                begin
                    blank_rows[wr_row] = 1'b0;
                end
                if (col_pos + 1 >= COLS)
                begin
                    col_pos = 0;
                    wr_row = step_row(wr_row);
                    if (wr_row == old_row)
                    begin
                        old_row = step_row(old_row);
                    end
                end
                else
                begin
                    col_pos = col_pos + 1;
                end
            end
            ACT_REMOVE:
            begin
                col_pos = 0;
                if (old_row != wr_row)
                begin
                    wr_row = (wr_row == 0) ? ROWS - 1 : wr_row - 1;
                end
                else
                begin
                    res.status = STATUS_EMPTY;
                end
            end
            default:
            begin
                if (rcol >= COLS || rrow >= ROWS)
                begin
                    res.status = STATUS_RANGE;
                end
                else if (rcol == 0 && blank_rows[rrow])
                begin
                    res.read_word = '0;
                end
                else
                begin
                    res.read_word = word_mem[rrow*COLS + rcol];
                end
            end
        endcase
        newest = (wr_row == 0) ? ROWS - 1 : wr_row - 1;
        held = (wr_row >= old_row) ? wr_row - old_row : wr_row + ROWS - old_row;
        res.newest_row = ROW_OUT_W'(newest);
        res.oldest_row = ROW_OUT_W'(old_row);
        res.row_count  = ROW_OUT_W'(held);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_result_t res;
        line_result_t want;
        if (!rst_n)
        begin
            blank_rows = '1;
            wr_row = 0;
            old_row = 0;
            col_pos = 0;
            beat_index = 0;
            fail_count = 0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_line_result(action_t'(s_axis_tuser), s_axis_tdata[15:0],
                                    s_axis_tdata[20:16], s_axis_tdata[27:21], res);
                expected_results.push_back(res);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("beat with nothing expected", m_axis_tdata, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[15:0] !== want.read_word)
                        report_mismatch("read_word", 32'(m_axis_tdata[15:0]),
                                        32'(want.read_word));
                    if (m_axis_tdata[20:16] !== want.newest_row)
                        report_mismatch("newest_row", 32'(m_axis_tdata[20:16]),
                                        32'(want.newest_row));
                    if (m_axis_tdata[25:21] !== want.oldest_row)
                        report_mismatch("oldest_row", 32'(m_axis_tdata[25:21]),
                                        32'(want.oldest_row));
                    if (m_axis_tdata[30:26] !== want.row_count)
                        report_mismatch("row_count", 32'(m_axis_tdata[30:26]),
                                        32'(want.row_count));
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                end
                beat_index = beat_index + 1;
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the history ring buffer testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
    import hrb_pkg::*;

    localparam int unsigned ROWS        = 32;
    localparam int unsigned COLS        = 80;
    localparam int unsigned IDLE_LIMIT  = 4000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_AFTER  = 400;
    localparam int unsigned FILL_ITEMS  = 1200;
    localparam int unsigned MIXED_ITEMS = 600;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    int          fail_count;
    int          outstanding;

    int unsigned items_sent   = 0;
    int unsigned burst_left   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned shadow_wr    = 0;
    int unsigned shadow_old   = 0;
    int unsigned shadow_col   = 0;
    bit          hold_done    = 1'b0;
    bit          cell_written [ROWS*COLS];

    history_ring_buffer_unit #(.ROWS(ROWS), .COLS(COLS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    history_ring_checker #(.ROWS(ROWS), .COLS(COLS)) result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // The stimulus keeps row pointers so random reads past column 0 hit written words.
    task automatic track_shadow(input action_t act);
        case (act)
            ACT_CLEAR:
            begin
                shadow_wr = 0;
                shadow_old = 0;
                shadow_col = 0;
            end
            ACT_APPEND:
            begin
                cell_written[shadow_wr*COLS + shadow_col] = 1'b1;
                if (shadow_col + 1 >= COLS)
                begin
                    shadow_col = 0;
                    shadow_wr = (shadow_wr + 1) % ROWS;
                    if (shadow_wr == shadow_old)
                    begin
                        shadow_old = (shadow_old + 1) % ROWS;
                    end
                end
                else
                begin
                    shadow_col = shadow_col + 1;
                end
            end
            ACT_REMOVE:
            begin
                shadow_col = 0;
                if (shadow_old != shadow_wr)
                begin
                    shadow_wr = (shadow_wr == 0) ? ROWS - 1 : shadow_wr - 1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_beat(input action_t act, input logic [15:0] value,
                             input logic [4:0] rrow, input logic [6:0] rcol);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0000, rcol, rrow, value};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        track_shadow(act);
        items_sent = items_sent + 1;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        else
        begin
            burst_left = burst_left - 1;
        end
    endtask

    task automatic send_random_read();
        int unsigned sel;
        logic [4:0]  rrow;
        logic [6:0]  rcol;
        sel = $urandom_range(0, 9);
        rrow = 5'($urandom);
        if (sel < 3)
        begin
            rcol = 7'($urandom_range(COLS, 127));
        end
        else if (sel < 5)
        begin
            rcol = '0;
        end
        else if (sel < 7 && shadow_col > 0)
        begin
            rrow = 5'(shadow_wr);
            rcol = 7'($urandom_range(0, shadow_col - 1));
        end
        else
        begin
            rcol = 7'($urandom_range(1, COLS - 1));
            if (!cell_written[rrow*COLS + rcol])
            begin
                rcol = '0;
            end
        end
        send_beat(ACT_READ, 16'($urandom), rrow, rcol);
    endtask

    task automatic send_random_append();
        send_beat(ACT_APPEND, 16'($urandom), 5'($urandom), 7'($urandom));
    endtask

    task automatic fill_row(input int unsigned read_pct);
        int unsigned left;
        left = COLS - shadow_col;
        repeat (left)
        begin
            send_random_append();
            if ($urandom_range(0, 99) < read_pct)
            begin
                send_random_read();
            end
        end
    endtask

    task automatic run_random_group(input bit allow_clear);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 88)
        begin
            fill_row(8);
        end
        else if (pick < 91)
        begin
            repeat ($urandom_range(1, COLS - 1)) send_random_append();
            send_beat(ACT_REMOVE, 16'($urandom), 5'($urandom), 7'($urandom));
        end
        else if (pick < 94)
        begin
            repeat ($urandom_range(1, 2))
                send_beat(ACT_REMOVE, 16'($urandom), 5'($urandom), 7'($urandom));
        end
        else if (pick < 98 || !allow_clear)
        begin
            repeat ($urandom_range(3, 10)) send_random_read();
        end
        else
        begin
            send_beat(ACT_CLEAR, 16'($urandom), 5'($urandom), 7'($urandom));
        end
    endtask

    initial
    begin
        int unsigned mixed_start;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_CLEAR;
        burst_left = $urandom_range(1, 20);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(ACT_READ,   16'h0000, 5'd0,  7'd0);
        send_beat(ACT_READ,   16'hFFFF, 5'd31, 7'd127);
        send_beat(ACT_READ,   16'h0000, 5'd0,  7'd80);
        send_beat(ACT_REMOVE, 16'hFFFF, 5'd31, 7'd127);
        send_beat(ACT_APPEND, 16'h0000, 5'd0,  7'd0);
        send_beat(ACT_APPEND, 16'hFFFF, 5'd31, 7'd127);
        send_beat(ACT_APPEND, 16'hA5A5, 5'd0,  7'd0);
        send_beat(ACT_READ,   16'h0000, 5'd0,  7'd0);
        send_beat(ACT_READ,   16'h0000, 5'd0,  7'd1);
        send_beat(ACT_READ,   16'h0000, 5'd0,  7'd2);
        send_beat(ACT_REMOVE, 16'h0000, 5'd0,  7'd0);
        send_beat(ACT_READ,   16'h0000, 5'd0,  7'd1);
        send_beat(ACT_APPEND, 16'h1234, 5'd0,  7'd0);
        send_beat(ACT_READ,   16'hFFFF, 5'd0,  7'd0);
        send_beat(ACT_CLEAR,  16'hFFFF, 5'd31, 7'd127);
        send_beat(ACT_READ,   16'h0000, 5'd0,  7'd0);
        send_beat(ACT_READ,   16'h0000, 5'd0,  7'd1);
        send_beat(ACT_READ,   16'h0000, 5'd31, 7'd0);
        send_beat(ACT_REMOVE, 16'h0000, 5'd0,  7'd0);
        send_beat(ACT_CLEAR,  16'h0000, 5'd0,  7'd0);

        // Fill a good part of the ring with rows before clears are allowed.
        while (items_sent < FILL_ITEMS)
        begin
            run_random_group(1'b0);
        end
        mixed_start = items_sent;
        while (items_sent < mixed_start + MIXED_ITEMS)
        begin
            run_random_group(1'b1);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial
    begin
        int unsigned mode;
        int unsigned span;
        int unsigned phase_cnt;
        mode = 0;
        span = 0;
        phase_cnt = 0;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_sent >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 120);
                    phase_cnt = 0;
                end
                span = span - 1;
                phase_cnt = phase_cnt + 1;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 99) < 70);
                    2:       m_axis_tready <= ($urandom_range(0, 99) < 25);
                    default: m_axis_tready <= ((phase_cnt % 7) < 4);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench: no beat accepted for %0d cycles", idle_cycles);
                $display("testbench: FAIL");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
